[rtl/dnrp_pkg.sv]
// Shared definitions for the directional nearest-rectangle picker.
// Holds default sizes, register indexes, direction codes and the stage control struct.
// No dependencies.
package dnrp_pkg;

  localparam int TAG_BITS_DEF   = 8;
  localparam int COORD_BITS_DEF = 16;
  localparam int CFG_IDX_BITS   = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_REF_X   = 3'd0,
    REG_REF_Y   = 3'd1,
    REG_REF_W   = 3'd2,
    REG_REF_H   = 3'd3,
    REG_DIR_SEL = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  // Per-candidate control carried down the pipeline.
  typedef struct packed {
    logic qual;
    logic last;
  } ctl_t;

endpackage

[rtl/dnrp_geom.sv]
// Geometry stage: doubled centers, direction test and center offsets.
// Registers the offsets and the control bits. Depends on dnrp_pkg.
module dnrp_geom import dnrp_pkg::*; #(
  parameter int TAG_BITS   = TAG_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] ref_x,
  input  logic signed [COORD_BITS-1:0] ref_y,
  input  logic        [COORD_BITS-2:0] ref_w,
  input  logic        [COORD_BITS-2:0] ref_h,
  input  dir_t                         dir_sel,
  input  logic signed [COORD_BITS-1:0] cand_x,
  input  logic signed [COORD_BITS-1:0] cand_y,
  input  logic        [COORD_BITS-2:0] cand_w,
  input  logic        [COORD_BITS-2:0] cand_h,
  input  logic        [TAG_BITS-1:0]   cand_tag,
  input  logic                         cand_skip,
  input  logic                         is_last,
  output logic signed [COORD_BITS+2:0] dx,
  output logic signed [COORD_BITS+2:0] dy,
  output logic        [TAG_BITS-1:0]   tag,
  output ctl_t                         ctl
);

  localparam int CTR_BITS = COORD_BITS + 2;

  logic signed [CTR_BITS-1:0]   rcx, rcy, ccx, ccy;
  logic signed [COORD_BITS+2:0] dx_next, dy_next;
  logic                         ahead;

  always_comb begin
    rcx = ({{2{ref_x[COORD_BITS-1]}}, ref_x} << 1) + {3'b000, ref_w};
    rcy = ({{2{ref_y[COORD_BITS-1]}}, ref_y} << 1) + {3'b000, ref_h};
    ccx = ({{2{cand_x[COORD_BITS-1]}}, cand_x} << 1) + {3'b000, cand_w};
    ccy = ({{2{cand_y[COORD_BITS-1]}}, cand_y} << 1) + {3'b000, cand_h};
    dx_next = {rcx[CTR_BITS-1], rcx} - {ccx[CTR_BITS-1], ccx};
    dy_next = {rcy[CTR_BITS-1], rcy} - {ccy[CTR_BITS-1], ccy};
    case (dir_sel)
      DIR_UP:    ahead = rcy > ccy;
      DIR_DOWN:  ahead = rcy < ccy;
      DIR_LEFT:  ahead = rcx > ccx;
      DIR_RIGHT: ahead = rcx < ccx;
      default:   ahead = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx       <= dx_next;
      dy       <= dy_next;
      tag      <= cand_tag;
      ctl.qual <= ahead && !cand_skip;
      ctl.last <= is_last;
    end
  end

endmodule

[rtl/dnrp_square.sv]
// Square stage: one signed square per axis, registered.
// Depends on dnrp_pkg.
module dnrp_square import dnrp_pkg::*; #(
  parameter int TAG_BITS   = TAG_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [COORD_BITS+2:0]   dx,
  input  logic signed [COORD_BITS+2:0]   dy,
  input  logic        [TAG_BITS-1:0]     tag_in,
  input  ctl_t                           ctl_in,
  output logic        [2*COORD_BITS+3:0] sq_x,
  output logic        [2*COORD_BITS+3:0] sq_y,
  output logic        [TAG_BITS-1:0]     tag,
  output ctl_t                           ctl
);

  localparam int DIFF_BITS = COORD_BITS + 3;
  localparam int SQ_BITS   = 2 * COORD_BITS + 4;

  logic signed [2*DIFF_BITS-1:0] prod_x, prod_y;

  // Offsets stay below 2**(COORD_BITS+2) in magnitude, so the squares fit.
  assign prod_x = dx * dx;
  assign prod_y = dy * dy;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x <= prod_x[SQ_BITS-1:0];
      sq_y <= prod_y[SQ_BITS-1:0];
      tag  <= tag_in;
      ctl  <= ctl_in;
    end
  end

endmodule

[rtl/dnrp_select.sv]
// Running minimum of squared distances and the result register.
// Depends on dnrp_pkg.
module dnrp_select import dnrp_pkg::*; #(
  parameter int TAG_BITS   = TAG_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic        [2*COORD_BITS+3:0] sq_x,
  input  logic        [2*COORD_BITS+3:0] sq_y,
  input  logic        [TAG_BITS-1:0]     tag,
  input  ctl_t                           ctl,
  input  logic                           res_stall,
  output logic                           res_valid,
  output logic                           found,
  output logic        [TAG_BITS-1:0]     best_tag
);

  localparam int DIST_BITS = 2 * COORD_BITS + 5;

  logic [DIST_BITS-1:0] cand_dist;
  logic [DIST_BITS-1:0] best_dist;
  logic [TAG_BITS-1:0]  best_id;
  logic                 have_best;
  logic                 take;

  // A strict compare keeps the earlier candidate on equal distance.
  assign cand_dist = {1'b0, sq_x} + {1'b0, sq_y};
  assign take = ctl.qual && (!have_best || cand_dist < best_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (en) begin
        have_best <= ctl.last ? 1'b0 : (have_best || take);
      end
      if (en && ctl.last) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && take) begin
      best_dist <= cand_dist;
      best_id   <= tag;
    end
    if (en && ctl.last) begin
      found    <= have_best || take;
      best_tag <= take ? tag : (have_best ? best_id : '0);
    end
  end

  a_no_tag_when_none: assert property (@(posedge clk) disable iff (rst)
    res_valid && !found |-> best_tag == '0)
    else $error("result without a find carries a nonzero tag");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    en && ctl.last |=> !have_best)
    else $error("search state not cleared after the last candidate");

  a_keep_after_qual: assert property (@(posedge clk) disable iff (rst)
    en && !ctl.last && ctl.qual |=> have_best)
    else $error("qualifying candidate not kept");

  a_load_on_last: assert property (@(posedge clk) disable iff (rst)
    en && ctl.last |=> res_valid)
    else $error("last candidate did not produce a result");

endmodule

[rtl/directional_nearest_rect_picker.sv]
// Directional nearest-rectangle picker, top level. An accepted candidate passes the
// input, geometry and square registers and commits in the select stage; the result of a
// last candidate is valid from that commit. Throughput: one candidate per cycle while
// cand_stall is low, through input register, geometry, square and select stages.
// Synchronous active-high reset clears configuration, stage valid bits and search state.
module directional_nearest_rect_picker import dnrp_pkg::*; #(
  parameter int TAG_BITS   = TAG_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // Configuration write port.
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_data,
  // Candidate channel.
  input  logic                    cand_valid,
  output logic                    cand_stall,
  input  logic [COORD_BITS-1:0]   cand_x,
  input  logic [COORD_BITS-1:0]   cand_y,
  input  logic [COORD_BITS-2:0]   cand_w,
  input  logic [COORD_BITS-2:0]   cand_h,
  input  logic [TAG_BITS-1:0]     cand_tag,
  input  logic                    cand_skip,
  input  logic                    is_last,
  // Result channel.
  output logic                    res_valid,
  input  logic                    res_stall,
  output logic                    found,
  output logic [TAG_BITS-1:0]     best_tag
);

  // Configuration registers.
  logic signed [COORD_BITS-1:0] ref_x, ref_y;
  logic        [COORD_BITS-2:0] ref_w, ref_h;
  dir_t                         dir_sel;

  // Stage one: the accepted transaction, held as received.
  logic                         v1;
  logic signed [COORD_BITS-1:0] s1_x, s1_y;
  logic        [COORD_BITS-2:0] s1_w, s1_h;
  logic        [TAG_BITS-1:0]   s1_tag;
  logic                         s1_skip, s1_last;

  // Stage two: center offsets.
  logic                         v2;
  logic signed [COORD_BITS+2:0] s2_dx, s2_dy;
  logic        [TAG_BITS-1:0]   s2_tag;
  ctl_t                         s2_ctl;

  // Stage three: squares.
  logic                           v3;
  logic        [2*COORD_BITS+3:0] s3_sqx, s3_sqy;
  logic        [TAG_BITS-1:0]     s3_tag;
  ctl_t                           s3_ctl;

  logic res_free, go1, go2, go3, accept;

  // Each stage moves on when the next one is empty or moving too. Only a last
  // candidate needs room in the result register; other candidates commit even
  // while a finished result waits to be taken.
  assign res_free   = !res_valid || !res_stall;
  assign go3        = v3 && (!s3_ctl.last || res_free);
  assign go2        = v2 && (!v3 || go3);
  assign go1        = v1 && (!v2 || go2);
  assign cand_stall = v1 && !go1;
  assign accept     = cand_valid && !cand_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x   <= '0;
      ref_y   <= '0;
      ref_w   <= '0;
      ref_h   <= '0;
      dir_sel <= DIR_UP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REF_X:   ref_x   <= cfg_data;
        REG_REF_Y:   ref_y   <= cfg_data;
        REG_REF_W:   ref_w   <= cfg_data[COORD_BITS-2:0];
        REG_REF_H:   ref_h   <= cfg_data[COORD_BITS-2:0];
        REG_DIR_SEL: dir_sel <= dir_t'(cfg_data[1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept || (v1 && !go1);
      v2 <= go1 || (v2 && !go2);
      v3 <= go2 || (v3 && !go3);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x    <= cand_x;
      s1_y    <= cand_y;
      s1_w    <= cand_w;
      s1_h    <= cand_h;
      s1_tag  <= cand_tag;
      s1_skip <= cand_skip;
      s1_last <= is_last;
    end
  end

  dnrp_geom #(
    .TAG_BITS   (TAG_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk       (clk),
    .en        (go1),
    .ref_x     (ref_x),
    .ref_y     (ref_y),
    .ref_w     (ref_w),
    .ref_h     (ref_h),
    .dir_sel   (dir_sel),
    .cand_x    (s1_x),
    .cand_y    (s1_y),
    .cand_w    (s1_w),
    .cand_h    (s1_h),
    .cand_tag  (s1_tag),
    .cand_skip (s1_skip),
    .is_last   (s1_last),
    .dx        (s2_dx),
    .dy        (s2_dy),
    .tag       (s2_tag),
    .ctl       (s2_ctl)
  );

  dnrp_square #(
    .TAG_BITS   (TAG_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_square (
    .clk    (clk),
    .en     (go2),
    .dx     (s2_dx),
    .dy     (s2_dy),
    .tag_in (s2_tag),
    .ctl_in (s2_ctl),
    .sq_x   (s3_sqx),
    .sq_y   (s3_sqy),
    .tag    (s3_tag),
    .ctl    (s3_ctl)
  );

  dnrp_select #(
    .TAG_BITS   (TAG_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_select (
    .clk       (clk),
    .rst       (rst),
    .en        (go3),
    .sq_x      (s3_sqx),
    .sq_y      (s3_sqy),
    .tag       (s3_tag),
    .ctl       (s3_ctl),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .found     (found),
    .best_tag  (best_tag)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    cand_stall |-> v1 && v2 && v3)
    else $error("candidate stalled while a stage was free");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    go3 && s3_ctl.last |-> res_free)
    else $error("result committed over a waiting result");

  a_stage_three_holds: assert property (@(posedge clk) disable iff (rst)
    v3 && !go3 |=> v3 && $stable(s3_tag))
    else $error("blocked candidate lost in the square stage");

endmodule
